### hdl/ptw_pkg.sv
// Shared types and constants for the two-level page walker.
`default_nettype none

package ptw_pkg;

  localparam int unsigned DefPageBytes   = 256;
  localparam int unsigned DefMemoryBytes = 65536;

  localparam int unsigned VaW    = 24;
  localparam int unsigned PageW  = 8;
  localparam int unsigned PaW    = 16;
  localparam int unsigned FaultW = 2;

  typedef enum logic [FaultW-1:0] {
    FAULT_NONE = 2'd0,
    FAULT_DIR  = 2'd1,
    FAULT_TBL  = 2'd2
  } fault_e;

  typedef enum logic {
    ACT_WRITE     = 1'b0,
    ACT_TRANSLATE = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIR_RD,
    ST_TBL_RD
  } ctrl_state_e;

  typedef enum logic [1:0] {
    ADDR_CLEAR,
    ADDR_DIR,
    ADDR_WRITE,
    ADDR_TABLE
  } addr_sel_e;

  typedef struct packed {
    addr_sel_e addr_sel;
    logic      mem_we;
    logic      mem_re;
    logic      clr_step;
    logic      va_load;
    logic      rsp_load;
    fault_e    rsp_fault;
  } ptw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic entry_zero;
  } ptw_stat_t;

endpackage

`default_nettype wire

### hdl/ptw_ifs.sv
// Valid/ready channel interfaces for walker request and response items.
`default_nettype none

interface ptw_req_if import ptw_pkg::*;;
  logic             valid;
  logic             ready;
  logic             action;
  logic [VaW-1:0]   virtual_address;
  logic [PageW-1:0] write_page;
  logic [PageW-1:0] write_entry;
  logic [PageW-1:0] write_value;

  modport source (output valid, action, virtual_address, write_page, write_entry,
                  write_value, input ready);
  modport sink (input valid, action, virtual_address, write_page, write_entry,
                write_value, output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PaW-1:0]    physical_address;
  logic [FaultW-1:0] fault;

  modport source (output valid, physical_address, fault, input ready);
  modport sink (input valid, physical_address, fault, output ready);
endinterface

`default_nettype wire

### hdl/ptw_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module ptw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/ptw_ctrl.sv
// Walker controller: clearing pass, item handshake and walk sequencing.
`default_nettype none

module ptw_ctrl import ptw_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  input  wire logic      req_action_i,
  output logic           req_ready_o,
  input  wire logic      rsp_ready_i,
  output logic           rsp_valid_o,
  input  wire ptw_stat_t stat_i,
  output ptw_cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        rsp_valid_q, rsp_valid_d;
  logic        out_free;
  logic        is_translate;

  assign out_free     = !rsp_valid_q || rsp_ready_i;
  assign is_translate = req_action_i == ACT_TRANSLATE;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i && is_translate) begin
          state_d = ST_DIR_RD;
        end
      end
      ST_DIR_RD: begin
        if (!stat_i.entry_zero) begin
          state_d = ST_TBL_RD;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_TBL_RD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.addr_sel  = ADDR_DIR;
    cmd_o.mem_we    = 1'b0;
    cmd_o.mem_re    = 1'b0;
    cmd_o.clr_step  = 1'b0;
    cmd_o.va_load   = 1'b0;
    cmd_o.rsp_load  = 1'b0;
    cmd_o.rsp_fault = FAULT_NONE;
    req_ready_o     = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.addr_sel = ADDR_CLEAR;
        cmd_o.mem_we   = 1'b1;
        cmd_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.addr_sel = is_translate ? ADDR_DIR : ADDR_WRITE;
        cmd_o.mem_we   = req_valid_i && !is_translate;
        cmd_o.mem_re   = req_valid_i && is_translate;
        cmd_o.va_load  = req_valid_i && is_translate;
      end
      ST_DIR_RD: begin
        if (!stat_i.entry_zero) begin
          cmd_o.addr_sel = ADDR_TABLE;
          cmd_o.mem_re   = 1'b1;
        end else if (out_free) begin
          cmd_o.rsp_load  = 1'b1;
          cmd_o.rsp_fault = FAULT_DIR;
        end
      end
      ST_TBL_RD: begin
        if (out_free) begin
          cmd_o.rsp_load  = 1'b1;
          cmd_o.rsp_fault = stat_i.entry_zero ? FAULT_TBL : FAULT_NONE;
        end
      end
      default: begin
        cmd_o.addr_sel = ADDR_CLEAR;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

`default_nettype wire

### hdl/ptw_dp.sv
// Walker datapath: address formation, page memory, directory register, result.
`default_nettype none

module ptw_dp import ptw_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = DefPageBytes,
  parameter int unsigned MEMORY_BYTES = DefMemoryBytes
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ptw_cmd_t         cmd_i,
  output ptw_stat_t             stat_o,
  input  wire logic             cfg_we_i,
  input  wire logic [PageW-1:0] cfg_wdata_i,
  input  wire logic [VaW-1:0]   virtual_address_i,
  input  wire logic [PageW-1:0] write_page_i,
  input  wire logic [PageW-1:0] write_entry_i,
  input  wire logic [PageW-1:0] write_value_i,
  output logic      [PaW-1:0]   physical_address_o,
  output logic      [FaultW-1:0] fault_o
);

  localparam int unsigned AW        = $clog2(MEMORY_BYTES);
  localparam int unsigned NumPages  = 2 ** PageW;

  logic [AW-1:0]      page_base [NumPages];
  logic [PageW-1:0]   dir_page_q;
  logic [AW-1:0]      clr_q;
  logic [2*PageW-1:0] va_q;
  logic [PageW-1:0]   rdata;
  logic [PageW-1:0]   page_sel;
  logic [PageW-1:0]   idx_sel;
  logic [AW:0]        addr_sum;
  logic [AW:0]        addr_wrap;
  logic [AW-1:0]      mem_addr;
  logic [PageW-1:0]   mem_wdata;
  logic [PaW-1:0]     pa_q;
  fault_e             fault_q;

  for (genvar g = 0; g < NumPages; g++) begin : g_page_base
    assign page_base[g] = AW'((g * PAGE_BYTES) % MEMORY_BYTES);
  end

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_WRITE: begin
        page_sel = write_page_i;
        idx_sel  = write_entry_i;
      end
      ADDR_TABLE: begin
        page_sel = rdata;
        idx_sel  = va_q[2*PageW-1:PageW];
      end
      default: begin
        page_sel = dir_page_q;
        idx_sel  = virtual_address_i[VaW-1:VaW-PageW];
      end
    endcase
  end

  assign addr_sum  = {1'b0, page_base[page_sel]} + (AW+1)'(idx_sel);
  assign addr_wrap = (addr_sum >= (AW+1)'(MEMORY_BYTES)) ?
                     addr_sum - (AW+1)'(MEMORY_BYTES) : addr_sum;
  assign mem_addr  = (cmd_i.addr_sel == ADDR_CLEAR) ? clr_q : addr_wrap[AW-1:0];
  assign mem_wdata = (cmd_i.addr_sel == ADDR_CLEAR) ? '0 : write_value_i;

  ptw_ram #(
    .WIDTH (PageW),
    .DEPTH (MEMORY_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .re_i    (cmd_i.mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (rdata)
  );

  assign stat_o.clr_last   = clr_q == AW'(MEMORY_BYTES - 1);
  assign stat_o.entry_zero = rdata == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_page_q <= '0;
      clr_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        dir_page_q <= cfg_wdata_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.va_load) begin
      va_q <= virtual_address_i[2*PageW-1:0];
    end
    if (cmd_i.rsp_load) begin
      fault_q <= cmd_i.rsp_fault;
      pa_q    <= (cmd_i.rsp_fault == FAULT_NONE) ? {rdata, va_q[PageW-1:0]} : '0;
    end
  end

  assign physical_address_o = pa_q;
  assign fault_o            = fault_q;

endmodule

`default_nettype wire

### hdl/two_level_page_walker.sv
// Walk: a translate item reads its directory entry, then its table entry, and
// loads the result; a zero directory entry loads a directory fault without the
// table read. An untaken response stalls the result load. Throughput: no item is
// taken during a walk, whose two reads of the single-port page memory depend on
// each other; a write item is taken every cycle while idle. Reset: a clearing pass
// zeroes the page memory, with req.ready low; the directory page register resets to 0.
`default_nettype none

module two_level_page_walker import ptw_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = DefPageBytes,
  parameter int unsigned MEMORY_BYTES = DefMemoryBytes
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ptw_req_if.sink               req,
  ptw_rsp_if.source             rsp,
  input  wire logic             cfg_we_i,
  input  wire logic [PageW-1:0] cfg_wdata_i
);

  ptw_cmd_t  cmd;
  ptw_stat_t stat;

  ptw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req.valid),
    .req_action_i (req.action),
    .req_ready_o  (req.ready),
    .rsp_ready_i  (rsp.ready),
    .rsp_valid_o  (rsp.valid),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  ptw_dp #(
    .PAGE_BYTES   (PAGE_BYTES),
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .virtual_address_i  (req.virtual_address),
    .write_page_i       (req.write_page),
    .write_entry_i      (req.write_entry),
    .write_value_i      (req.write_value),
    .physical_address_o (rsp.physical_address),
    .fault_o            (rsp.fault)
  );

endmodule

`default_nettype wire

### hdl/ptw_checker.sv
// Port-level assertions for the page walker, bound to the top level.
`default_nettype none

module ptw_checker import ptw_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic              req_action_i,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire logic [PaW-1:0]    rsp_pa_i,
  input wire logic [FaultW-1:0] rsp_fault_i
);

  logic req_fire;

  assign req_fire = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_pa_i))
    else $error("Stalled response item changed or dropped.");

  a_fault_zero_pa: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_fault_i != FAULT_NONE |-> rsp_pa_i == '0)
    else $error("Faulting item carries a nonzero physical address.");

  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && req_action_i |=> !req_ready_i)
    else $error("Request taken during a table walk.");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && !req_action_i && !rsp_valid_i |=> !rsp_valid_i)
    else $error("Write item produced a response item.");

endmodule

bind two_level_page_walker ptw_checker u_ptw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req.valid),
  .req_ready_i  (req.ready),
  .req_action_i (req.action),
  .rsp_valid_i  (rsp.valid),
  .rsp_ready_i  (rsp.ready),
  .rsp_pa_i     (rsp.physical_address),
  .rsp_fault_i  (rsp.fault)
);

`default_nettype wire

### tb/ptw_walk_checker.sv
// Checker that mirrors the page walker, predicts each response item and compares it.
`default_nettype none

module ptw_walk_checker import ptw_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  ptw_req_if                    req,
  ptw_rsp_if                    rsp,
  input  wire logic             cfg_we_i,
  input  wire logic [PageW-1:0] cfg_wdata_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [PaW-1:0] physical_address;
    fault_e         fault;
  } walk_result_t;

  logic [PageW-1:0] page_mem [DefMemoryBytes];
  logic [PageW-1:0] directory_page;
  walk_result_t     expected_walks [$];
  int               mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: response mismatch: %s", $time, what);
  endtask

  function automatic walk_result_t translate_address(input logic [VaW-1:0] va);
    logic [PageW-1:0] table_page;
    logic [PageW-1:0] data_page;
    walk_result_t     res;
    res.physical_address = '0;
    res.fault            = FAULT_NONE;
    table_page = page_mem[{directory_page, va[23:16]}];
    if (table_page == '0) begin
      res.fault = FAULT_DIR;
    end else begin
      data_page = page_mem[{table_page, va[15:8]}];
      if (data_page == '0) begin
        res.fault = FAULT_TBL;
      end else begin
        res.physical_address = {data_page, va[7:0]};
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : model
    walk_result_t want;
    if (!rst_ni) begin
      foreach (page_mem[i]) page_mem[i] = '0;
      directory_page = '0;
      expected_walks.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_walks.size() == 0) begin
          report_mismatch($sformatf("unexpected item pa=%h fault=%0d",
                                    rsp.physical_address, rsp.fault));
        end else begin
          want = expected_walks.pop_front();
          if (rsp.physical_address !== want.physical_address) begin
            report_mismatch($sformatf("physical_address got %h want %h",
                                      rsp.physical_address, want.physical_address));
          end
          if (rsp.fault !== want.fault) begin
            report_mismatch($sformatf("fault got %0d want %0d", rsp.fault, want.fault));
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.action == 1'(ACT_TRANSLATE)) begin
          expected_walks.push_back(translate_address(req.virtual_address));
        end else begin
          page_mem[{req.write_page, req.write_entry}] = req.write_value;
        end
      end
      if (cfg_we_i) begin
        directory_page = cfg_wdata_i;
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_walks.size();
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// Top of the page walker testbench: clock, reset, stimulus, stalls and verdict.
`default_nettype none

module tb_top;
  import ptw_pkg::*;

  localparam int CycleLimit = 400_000;
  localparam int PhaseItems = 115;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [PageW-1:0] cfg_wdata_i;
  int               mismatches;
  int               pending;
  int               items_sent = 0;
  int               cycle_count = 0;
  logic             rsp_hold = 1'b0;
  bit               sender_quiet = 1'b0;
  bit               receiver_quiet = 1'b0;

  logic [PageW-1:0] dir_indexes [4];
  logic [PageW-1:0] table_pages [3];
  logic [PageW-1:0] table_indexes [4];

  ptw_req_if req_ch ();
  ptw_rsp_if rsp_ch ();

  two_level_page_walker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  ptw_walk_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req              (req_ch),
    .rsp              (rsp_ch),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_item(input logic act, input logic [VaW-1:0] va,
                           input logic [PageW-1:0] page, input logic [PageW-1:0] entry,
                           input logic [PageW-1:0] value);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid           <= 1'b1;
    req_ch.action          <= act;
    req_ch.virtual_address <= va;
    req_ch.write_page      <= page;
    req_ch.write_entry     <= entry;
    req_ch.write_value     <= value;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic store_byte(input logic [PageW-1:0] page, input logic [PageW-1:0] entry,
                            input logic [PageW-1:0] value);
    send_item(1'(ACT_WRITE), VaW'($urandom()), page, entry, value);
  endtask

  task automatic walk_address(input logic [VaW-1:0] va);
    send_item(1'(ACT_TRANSLATE), va, PageW'($urandom()), PageW'($urandom()),
              PageW'($urandom()));
  endtask

  // The block must be idle before the directory register changes.
  task automatic set_directory(input logic [PageW-1:0] value);
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [PageW-1:0] dir_page);
    int               pick;
    logic [PageW-1:0] value;
    foreach (dir_indexes[i]) dir_indexes[i] = PageW'($urandom());
    foreach (table_pages[i]) table_pages[i] = PageW'($urandom_range(1, 255));
    foreach (table_indexes[i]) table_indexes[i] = PageW'($urandom());
    for (int n = 0; n < PhaseItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        value = ($urandom_range(0, 7) == 0) ? '0 : table_pages[$urandom_range(0, 2)];
        store_byte(dir_page, dir_indexes[$urandom_range(0, 3)], value);
      end else if (pick < 35) begin
        value = ($urandom_range(0, 7) == 0) ? '0 : PageW'($urandom());
        store_byte(table_pages[$urandom_range(0, 2)], table_indexes[$urandom_range(0, 3)],
                   value);
      end else if (pick < 85) begin
        walk_address({dir_indexes[$urandom_range(0, 3)], table_indexes[$urandom_range(0, 3)],
                      PageW'($urandom())});
      end else if (pick < 92) begin
        store_byte(PageW'($urandom()), PageW'($urandom()), PageW'($urandom()));
      end else begin
        walk_address(VaW'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    logic [PageW-1:0] dir_values [6];
    rst_ni                 = 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_wdata_i           <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.action         <= 1'b0;
    req_ch.virtual_address <= '0;
    req_ch.write_page     <= '0;
    req_ch.write_entry    <= '0;
    req_ch.write_value    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directory at page zero straight out of reset: faults at both levels,
    // full-range addresses and overwritten entries.
    walk_address(24'h000000);
    walk_address(24'hFFFFFF);
    store_byte(8'h00, 8'h12, 8'h05);
    walk_address(24'h123456);
    store_byte(8'h05, 8'h34, 8'hAB);
    walk_address(24'h123456);
    walk_address(24'h1234FF);
    walk_address(24'h123400);
    store_byte(8'h00, 8'hFF, 8'hFF);
    store_byte(8'hFF, 8'hFF, 8'hFF);
    walk_address(24'hFFFFFF);
    store_byte(8'hFF, 8'h00, 8'h01);
    walk_address(24'hFF00AA);
    store_byte(8'h00, 8'h00, 8'hFF);
    walk_address(24'h000077);
    store_byte(8'h00, 8'h12, 8'h00);
    walk_address(24'h123456);
    store_byte(8'hFF, 8'hFF, 8'h00);
    walk_address(24'hFFFF00);

    // The top page now serves as directory, with entries already in it.
    set_directory(8'hFF);
    walk_address(24'h0000C3);
    walk_address(24'hFFFFFF);

    dir_values = '{8'hFF, 8'h00, 8'h80, 8'h01, PageW'($urandom()), PageW'($urandom())};
    foreach (dir_values[i]) begin
      set_directory(dir_values[i]);
      run_phase(dir_values[i]);
    end

    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("two_level_page_walker test passed");
    end else begin
      $display("two_level_page_walker test failed");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 29) == 0) receiver_quiet = !receiver_quiet;
      stall = receiver_quiet ? 0 : $urandom_range(0, 11);
      if (stall != 0 || rsp_hold) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (rsp_hold) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
    end
  end

  initial begin : long_hold
    wait (items_sent >= 150);
    @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("two_level_page_walker test failed");
    $finish;
  end

endmodule

`default_nettype wire
